[hw/rtl/mmca_pkg.sv]
`default_nettype none

package mmca_pkg;

    // Fixed field widths
    localparam int BTN_W       = 16;
    localparam int POS_W       = 16;
    localparam int STAMP_W     = 32;
    localparam int TM_W        = 16;
    localparam int DCT_W       = 8;
    localparam int GAP_W       = 5;
    localparam int TOTAL_W     = 8;
    localparam int CNT_W       = 4;
    localparam int PACKED_W    = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // Defaults and limits
    localparam int NUM_BUTTONS_DEF = 16;
    localparam int MID_DEPTH       = 2;
    localparam int OUT_DEPTH       = 2;

    localparam logic [DCT_W-1:0] DC_MAX    = 8'd200;
    localparam logic [DCT_W-1:0] DC_RESET  = 8'd50;
    localparam logic [GAP_W-1:0] GAP_MAX   = 5'd20;
    localparam logic [GAP_W-1:0] GAP_RESET = 5'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_GAP   = 2'd1;

    typedef enum logic
    {
        KIND_EVENT = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    // Item as seen at the input ports
    typedef struct packed
    {
        kind_t                    kind;
        logic [BTN_W-1:0]         buttons;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [STAMP_W-1:0]       stamp;
    } in_item_t;

    // Item after bounce filtering, handed to the back end
    typedef struct packed
    {
        kind_t                    kind;
        logic [BTN_W-1:0]         buttons;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic [TM_W-1:0]          tm;
    } mid_item_t;

    // Aggregated click packet
    typedef struct packed
    {
        logic signed [POS_W-1:0]  first_x;
        logic signed [POS_W-1:0]  first_y;
        logic signed [POS_W-1:0]  now_x;
        logic signed [POS_W-1:0]  now_y;
        logic [BTN_W-1:0]         buttons_seen;
        logic [BTN_W-1:0]         buttons_now;
        logic [TOTAL_W-1:0]       total_clicks;
        logic [PACKED_W-1:0]      per_button_clicks;
    } out_rec_t;

endpackage

`default_nettype wire

[hw/rtl/mmca_fifo.sv]
`default_nettype none

module mmca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("fifo written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("fifo read while empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/mmca_front.sv]
`default_nettype none

module mmca_front #(
    parameter int NUM_BUTTONS = mmca_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire mmca_pkg::in_item_t            in_item,
    input  wire logic [mmca_pkg::GAP_W-1:0]    gap_ticks,
    input  wire logic                          mid_full,
    output logic                               mid_wr,
    output mmca_pkg::mid_item_t                mid_item
);

    localparam logic [1:0] GAP_WINDOW_LEN = 2'd2;

    logic [1:0]                      gw_reg, gw_next;
    logic [mmca_pkg::STAMP_W-1:0]    pes_reg, pes_next;
    logic                            accept;
    logic                            drop;
    logic [mmca_pkg::BTN_W-1:0]      btn_m;
    logic [mmca_pkg::STAMP_W-1:0]    diff;
    logic                            short_gap;

    // Buttons above NUM_BUTTONS read as released
    always_comb
    begin
        for (int i = 0; i < mmca_pkg::BTN_W; i++)
        begin
            btn_m[i] = (i < NUM_BUTTONS) ? in_item.buttons[i] : 1'b0;
        end
    end

    assign accept    = push && !mid_full;
    assign diff      = in_item.stamp - pes_reg;
    assign short_gap = diff[mmca_pkg::STAMP_W-1]
                       || (diff <= {{(mmca_pkg::STAMP_W - mmca_pkg::GAP_W){1'b0}}, gap_ticks});

    // Bounce window and drop decision
    always_comb
    begin
        gw_next  = gw_reg;
        pes_next = pes_reg;
        drop     = 1'b0;
        if (accept)
        begin
            if (in_item.kind == mmca_pkg::KIND_TICK)
            begin
                if (gw_reg != 2'd0)
                begin
                    gw_next = gw_reg - 1'b1;
                end
            end
            else if (gw_reg != 2'd0)
            begin
                pes_next = in_item.stamp;
                drop     = (btn_m != '0) && short_gap;
            end
            else
            begin
                gw_next  = GAP_WINDOW_LEN;
                pes_next = in_item.stamp;
            end
        end
    end

    // Forwarded item
    always_comb
    begin
        mid_wr           = accept && !drop;
        mid_item.kind    = in_item.kind;
        mid_item.buttons = btn_m;
        mid_item.pos_x   = in_item.pos_x;
        mid_item.pos_y   = in_item.pos_y;
        mid_item.tm      = in_item.stamp[mmca_pkg::TM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg  <= '0;
            pes_reg <= '0;
        end
        else
        begin
            gw_reg  <= gw_next;
            pes_reg <= pes_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mmca_back.sv]
`default_nettype none

module mmca_back #(
    parameter int NUM_BUTTONS = mmca_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mmca_pkg::mid_item_t           item,
    input  wire logic                          item_valid,
    output logic                               item_take,
    input  wire logic [mmca_pkg::DCT_W-1:0]    dc_ticks,
    input  wire logic                          out_full,
    output logic                               out_wr,
    output mmca_pkg::out_rec_t                 out_rec
);

    localparam int BW = mmca_pkg::BTN_W;
    localparam int TW = mmca_pkg::TM_W;
    localparam logic [TW:0] EXTEND_TICKS = 17'd10;

    // Window state
    logic [BW-1:0]                   prev_reg, prev_next;
    logic [BW-1:0]                   seen_reg, seen_next;
    logic [BW-1:0]                   latest_reg, latest_next;
    logic signed [mmca_pkg::POS_W-1:0] start_x_reg, start_x_next;
    logic signed [mmca_pkg::POS_W-1:0] start_y_reg, start_y_next;
    logic [TW-1:0]                   pcs_reg, pcs_next;
    logic [TW-1:0]                   tl_reg, tl_next;
    logic [mmca_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [mmca_pkg::CNT_W-1:0]      cnt_reg [NUM_BUTTONS];
    logic [mmca_pkg::CNT_W-1:0]      cnt_next [NUM_BUTTONS];

    // Working values
    logic                            ev, same, open_ev, new_ev, check_en, emit;
    logic [BW-1:0]                   s, rise;
    logic [mmca_pkg::CNT_W-1:0]      cnt_b [NUM_BUTTONS];
    logic [4:0]                      rise_cnt;
    logic [mmca_pkg::TOTAL_W:0]      tsum;
    logic [mmca_pkg::TOTAL_W-1:0]    total_b;
    logic                            ext;
    logic [TW-1:0]                   tl_ext, elapsed, tl_chk;
    logic [mmca_pkg::PACKED_W-1:0]   cnt_packed_b, cnt_packed_reg;

    function automatic logic [TW-1:0] sat16(input logic [TW:0] v);
        if (v[TW] != v[TW-1])
        begin
            return v[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
        end
        return v[TW-1:0];
    endfunction

    assign item_take = item_valid && !out_full;
    assign out_wr    = item_take && emit;

    // Classify the item against the window state
    always_comb
    begin
        s        = item.buttons;
        ev       = (item.kind == mmca_pkg::KIND_EVENT);
        same     = (s == prev_reg);
        open_ev  = ev && !same && (tl_reg != '0);
        new_ev   = ev && !same && (tl_reg == '0);
        rise     = open_ev ? (s & ~prev_reg) : (new_ev ? s : '0);
    end

    // Click counting
    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            cnt_b[i] = (rise[i] && cnt_reg[i] != '1) ? cnt_reg[i] + 1'b1 : cnt_reg[i];
        end
        rise_cnt = 5'($countones(rise));
        tsum     = {1'b0, total_reg} + 9'(rise_cnt);
        total_b  = tsum[mmca_pkg::TOTAL_W] ? '1 : tsum[mmca_pkg::TOTAL_W-1:0];
    end

    // Window extension and timeout check
    always_comb
    begin
        ext      = open_ev && (total_b > 8'd1);
        tl_ext   = ext ? sat16({tl_reg[TW-1], tl_reg} + EXTEND_TICKS) : tl_reg;
        check_en = !new_ev && (tl_ext != '0);
        elapsed  = item.tm - pcs_reg;
        tl_chk   = sat16({tl_ext[TW-1], tl_ext} - {elapsed[TW-1], elapsed});
        emit     = (check_en && (tl_chk[TW-1] || tl_chk == '0)) || (new_ev && s == '0);
    end

    // Next state
    always_comb
    begin
        prev_next    = (open_ev || new_ev) ? s : prev_reg;
        latest_next  = (open_ev || new_ev) ? s : latest_reg;
        seen_next    = open_ev ? (seen_reg | s) : (new_ev ? s : seen_reg);
        start_x_next = new_ev ? item.pos_x : start_x_reg;
        start_y_next = new_ev ? item.pos_y : start_y_reg;
        pcs_next     = pcs_reg;
        tl_next      = check_en ? tl_chk : tl_ext;
        if (check_en || (new_ev && s != '0))
        begin
            pcs_next = item.tm;
        end
        if (new_ev && s != '0)
        begin
            tl_next = {{(TW - mmca_pkg::DCT_W){1'b0}}, dc_ticks};
        end
        total_next = total_b;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            cnt_next[i] = cnt_b[i];
        end
        // Emission clears the counts and closes the window
        if (emit)
        begin
            total_next = '0;
            tl_next    = '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cnt_next[i] = '0;
            end
        end
    end

    // Packed per-button counts
    always_comb
    begin
        cnt_packed_b   = '0;
        cnt_packed_reg = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            cnt_packed_b[i*mmca_pkg::CNT_W +: mmca_pkg::CNT_W]   = cnt_b[i];
            cnt_packed_reg[i*mmca_pkg::CNT_W +: mmca_pkg::CNT_W] = cnt_reg[i];
        end
    end

    // Result packet
    always_comb
    begin
        out_rec.first_x           = start_x_next;
        out_rec.first_y           = start_y_next;
        out_rec.now_x             = item.pos_x;
        out_rec.now_y             = item.pos_y;
        out_rec.buttons_seen      = seen_next;
        out_rec.buttons_now       = latest_next;
        out_rec.total_clicks      = total_b;
        out_rec.per_button_clicks = cnt_packed_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            seen_reg    <= '0;
            latest_reg  <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            pcs_reg     <= '0;
            tl_reg      <= '0;
            total_reg   <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (item_take)
        begin
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            latest_reg  <= latest_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            pcs_reg     <= pcs_next;
            tl_reg      <= tl_next;
            total_reg   <= total_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_wr |=> (tl_reg == '0) && (total_reg == '0))
        else $error("window state not cleared after emission");

    a_ticks_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !tl_reg[TW-1])
        else $error("remaining ticks negative between items");

    a_counts_follow_total: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg == '0) |-> (cnt_packed_reg == '0))
        else $error("per-button count set while total is zero");
`endif

endmodule

`default_nettype wire

[hw/rtl/mouse_multi_click_aggregator_top.sv]
// Mouse multi-click aggregator.
// Input channel: push/full queue interface carrying kind (0 button event,
// 1 timer tick), buttons, pos_x, pos_y and stamp. A transfer happens on a
// rising edge with push high and full low.
// Result channel: empty/pop queue interface. While empty is low the oldest
// click packet sits on first_x .. per_button_clicks; a transfer happens on
// a rising edge with pop high and empty low.
// Config channel: cfg_valid/cfg_ready (ready always high); cfg_index 0 is
// the click window length, 1 the bounce gap. Window lengths above 200 clamp;
// the gap takes cfg_data's low 5 bits and clamps above 20. A packet caused
// by an item is registered in the middle queue, then in the result queue,
// before it shows on the result ports. One item per cycle while full is low.
// A front stage drops bounced presses and feeds a 2-deep queue; the back end
// updates the window and writes packets into a 2-deep result queue.
// If the receiver stalls, the result queue fills, the back end holds, the
// middle queue fills and full goes high; nothing is lost.
// Reset: queues empty, window closed, counts zero, config back to 50 and 3.
`default_nettype none

module mouse_multi_click_aggregator_top #(
    parameter int NUM_BUTTONS = mmca_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic                                kind,
    input  wire logic [mmca_pkg::BTN_W-1:0]          buttons,
    input  wire logic signed [mmca_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [mmca_pkg::POS_W-1:0]   pos_y,
    input  wire logic [mmca_pkg::STAMP_W-1:0]        stamp,
    // result channel
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [mmca_pkg::POS_W-1:0]        first_x,
    output logic signed [mmca_pkg::POS_W-1:0]        first_y,
    output logic signed [mmca_pkg::POS_W-1:0]        now_x,
    output logic signed [mmca_pkg::POS_W-1:0]        now_y,
    output logic [mmca_pkg::BTN_W-1:0]               buttons_seen,
    output logic [mmca_pkg::BTN_W-1:0]               buttons_now,
    output logic [mmca_pkg::TOTAL_W-1:0]             total_clicks,
    output logic [mmca_pkg::PACKED_W-1:0]            per_button_clicks,
    // config channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mmca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mmca_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int MID_W = $bits(mmca_pkg::mid_item_t);
    localparam int OUT_W = $bits(mmca_pkg::out_rec_t);

    logic [mmca_pkg::DCT_W-1:0]  dct_reg, dct_next;
    logic [mmca_pkg::GAP_W-1:0]  gap_reg, gap_next;
    logic [mmca_pkg::GAP_W-1:0]  cfg_gap_val;

    mmca_pkg::in_item_t          in_item;
    mmca_pkg::mid_item_t         mid_wr_item, mid_rd_item;
    logic [MID_W-1:0]            mid_rd_data;
    logic                        mid_wr, mid_full, mid_empty, mid_take;
    mmca_pkg::out_rec_t          out_wr_rec, out_rd_rec;
    logic [OUT_W-1:0]            out_rd_data;
    logic                        out_wr, out_full, out_rd;

    // Configuration registers
    assign cfg_ready   = 1'b1;
    assign cfg_gap_val = cfg_data[mmca_pkg::GAP_W-1:0];

    always_comb
    begin
        dct_next = dct_reg;
        gap_next = gap_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mmca_pkg::CFG_DOUBLE_CLICK:
                begin
                    dct_next = (cfg_data > mmca_pkg::DC_MAX) ? mmca_pkg::DC_MAX : cfg_data;
                end
                mmca_pkg::CFG_BOUNCE_GAP:
                begin
                    gap_next = (cfg_gap_val > mmca_pkg::GAP_MAX) ? mmca_pkg::GAP_MAX
                                                                 : cfg_gap_val;
                end
                default:
                begin
                    dct_next = dct_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dct_reg <= mmca_pkg::DC_RESET;
            gap_reg <= mmca_pkg::GAP_RESET;
        end
        else
        begin
            dct_reg <= dct_next;
            gap_reg <= gap_next;
        end
    end

    // Input item
    always_comb
    begin
        in_item.kind    = mmca_pkg::kind_t'(kind);
        in_item.buttons = buttons;
        in_item.pos_x   = pos_x;
        in_item.pos_y   = pos_y;
        in_item.stamp   = stamp;
    end

    assign full = mid_full;

    mmca_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .gap_ticks (gap_reg),
        .mid_full  (mid_full),
        .mid_wr    (mid_wr),
        .mid_item  (mid_wr_item)
    );

    mmca_fifo #(
        .WIDTH (MID_W),
        .DEPTH (mmca_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wr_item),
        .full    (mid_full),
        .rd_en   (mid_take),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign mid_rd_item = mmca_pkg::mid_item_t'(mid_rd_data);

    mmca_back #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_rd_item),
        .item_valid (!mid_empty),
        .item_take  (mid_take),
        .dc_ticks   (dct_reg),
        .out_full   (out_full),
        .out_wr     (out_wr),
        .out_rec    (out_wr_rec)
    );

    assign out_rd = pop && !empty;

    mmca_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (mmca_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wr_rec),
        .full    (out_full),
        .rd_en   (out_rd),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    // Result ports
    always_comb
    begin
        out_rd_rec        = mmca_pkg::out_rec_t'(out_rd_data);
        first_x           = out_rd_rec.first_x;
        first_y           = out_rd_rec.first_y;
        now_x             = out_rd_rec.now_x;
        now_y             = out_rd_rec.now_y;
        buttons_seen      = out_rd_rec.buttons_seen;
        buttons_now       = out_rd_rec.buttons_now;
        total_clicks      = out_rd_rec.total_clicks;
        per_button_clicks = out_rd_rec.per_button_clicks;
    end

endmodule

`default_nettype wire
